// ===== rtl/mpts_pkg.sv =====
// Shared types, codes and the control-store contents of the memory pattern test sequencer.
package mpts_pkg;

  // Defaults for the top-level parameters
  localparam int WordBitsDef    = 32;
  localparam int WalkLimitDef   = 65536;
  localparam logic [31:0] SizeResetVal = 32'h0001_0000;

  // Memory command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } mem_cmd_t;

  // Run status codes
  typedef enum logic [1:0] {
    ST_NOT_RUN = 2'd0,
    ST_PASS    = 2'd1,
    ST_FAIL    = 2'd2
  } test_status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE = 2'd0,
    CFG_SIZE = 2'd1,
    CFG_MODE = 2'd2
  } cfg_idx_t;

  // Test phases; the phase is also the microprogram address
  typedef enum logic [2:0] {
    PH_ZERO  = 3'd0,
    PH_ONES  = 3'd1,
    PH_AA    = 3'd2,
    PH_55    = 3'd3,
    PH_WALK  = 3'd4,
    PH_ADDR  = 3'd5,
    PH_DRAIN = 3'd6
  } phase_t;

  // Data pattern selects
  typedef enum logic [2:0] {
    PAT_ZERO = 3'd0,
    PAT_ONES = 3'd1,
    PAT_AA   = 3'd2,
    PAT_55   = 3'd3,
    PAT_WALK = 3'd4,
    PAT_ADDR = 3'd5
  } pat_sel_t;

  // One control word of the microprogram
  typedef struct packed {
    pat_sel_t pat;        // data pattern of this step
    logic     walk_loop;  // repeat the step once per bit position
    logic     walk_gate;  // skip the next step when the region is too large
    logic     quick_end;  // quick mode stops after this step
    phase_t   next_ph;    // jump target after the read pass
  } ucode_t;

  // Control word bundle from the sequencer to the datapath
  typedef struct packed {
    logic        start;     // idle and run requested
    logic        issue;     // a memory command goes out this tick
    logic        done;      // run finishes this tick
    logic        verify;    // read pass (else write pass)
    pat_sel_t    pat;
    logic [4:0]  bit_pos;
    logic [29:0] word_idx;
    phase_t      phase;
  } seq_ctl_t;

  // Read-only control store
  function automatic ucode_t ucode_rom(input phase_t ph);
    ucode_t uc;
    unique case (ph)
      PH_ZERO: uc = '{pat: PAT_ZERO, walk_loop: 1'b0, walk_gate: 1'b0, quick_end: 1'b0,
                      next_ph: PH_ONES};
      PH_ONES: uc = '{pat: PAT_ONES, walk_loop: 1'b0, walk_gate: 1'b0, quick_end: 1'b0,
                      next_ph: PH_AA};
      PH_AA:   uc = '{pat: PAT_AA, walk_loop: 1'b0, walk_gate: 1'b0, quick_end: 1'b0,
                      next_ph: PH_55};
      PH_55:   uc = '{pat: PAT_55, walk_loop: 1'b0, walk_gate: 1'b1, quick_end: 1'b1,
                      next_ph: PH_WALK};
      PH_WALK: uc = '{pat: PAT_WALK, walk_loop: 1'b1, walk_gate: 1'b0, quick_end: 1'b1,
                      next_ph: PH_ADDR};
      PH_ADDR: uc = '{pat: PAT_ADDR, walk_loop: 1'b0, walk_gate: 1'b0, quick_end: 1'b1,
                      next_ph: PH_DRAIN};
      default: uc = '{pat: PAT_ZERO, walk_loop: 1'b0, walk_gate: 1'b0, quick_end: 1'b1,
                      next_ph: PH_DRAIN};
    endcase
    return uc;
  endfunction

endpackage

// ===== rtl/mpts_seq.sv =====
// Microcoded sequencer: step counter, word and bit counters, control-store jumps.
module mpts_seq #(
  parameter int WORD_BITS        = mpts_pkg::WordBitsDef,
  parameter int WALK_LIMIT_BYTES = mpts_pkg::WalkLimitDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              func,
  input  logic [31:0]       size_bytes,
  input  logic              test_mode,
  output mpts_pkg::seq_ctl_t ctl
);
  import mpts_pkg::*;

  localparam int PatBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [4:0]  WalkLast  = 5'(PatBits - 1);
  localparam logic [31:0] WalkLimit = 32'(WALK_LIMIT_BYTES);

  logic        running_r, running_nxt;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  bit_pos_r, bit_pos_nxt;
  logic [29:0] word_idx_r, word_idx_nxt;
  logic        verify_r, verify_nxt;

  ucode_t      uc;
  logic [29:0] words;
  logic [29:0] word_inc;
  logic        drain;
  logic        pass_end;
  phase_t      jump_ph;

  // Control word fetch and conditional jump target
  always_comb begin
    uc       = ucode_rom(phase_r);
    words    = size_bytes[31:2];
    word_inc = word_idx_r + 30'd1;
    drain    = (words == '0) || (phase_r == PH_DRAIN);
    pass_end = (word_inc >= words) || (word_inc == '0);
    if (test_mode && uc.quick_end) begin
      jump_ph = PH_DRAIN;
    end else if (uc.walk_gate && (size_bytes > WalkLimit)) begin
      jump_ph = PH_ADDR;
    end else begin
      jump_ph = uc.next_ph;
    end
  end

  // Next state
  always_comb begin
    running_nxt  = running_r;
    phase_nxt    = phase_r;
    bit_pos_nxt  = bit_pos_r;
    word_idx_nxt = word_idx_r;
    verify_nxt   = verify_r;
    if (step) begin
      if (!running_r) begin
        if (func) begin
          running_nxt  = 1'b1;
          phase_nxt    = PH_ZERO;
          bit_pos_nxt  = '0;
          word_idx_nxt = '0;
          verify_nxt   = 1'b0;
        end
      end else if (drain) begin
        running_nxt  = 1'b0;
        phase_nxt    = PH_ZERO;
        bit_pos_nxt  = '0;
        word_idx_nxt = '0;
        verify_nxt   = 1'b0;
      end else begin
        word_idx_nxt = pass_end ? '0 : word_inc;
        if (pass_end) begin
          if (!verify_r) begin
            verify_nxt = 1'b1;
          end else begin
            verify_nxt = 1'b0;
            if (uc.walk_loop && (bit_pos_r < WalkLast)) begin
              bit_pos_nxt = bit_pos_r + 5'd1;
            end else begin
              bit_pos_nxt = '0;
              phase_nxt   = jump_ph;
            end
          end
        end
      end
    end
  end

  // Control outputs
  always_comb begin
    ctl.start    = !running_r && func;
    ctl.issue    = running_r && !drain;
    ctl.done     = running_r && drain;
    ctl.verify   = verify_r;
    ctl.pat      = uc.pat;
    ctl.bit_pos  = bit_pos_r;
    ctl.word_idx = word_idx_r;
    ctl.phase    = phase_r;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      phase_r    <= PH_ZERO;
      bit_pos_r  <= '0;
      word_idx_r <= '0;
      verify_r   <= 1'b0;
    end else begin
      running_r  <= running_nxt;
      phase_r    <= phase_nxt;
      bit_pos_r  <= bit_pos_nxt;
      word_idx_r <= word_idx_nxt;
      verify_r   <= verify_nxt;
    end
  end

`ifndef SYNTH
  // Finishing a run always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ctl.done) |=> (!running_r && phase_r == PH_ZERO && !verify_r))
    else $error("sequencer not idle after run end");

  // A start lands on the first step with counters cleared
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ctl.start) |=> (running_r && phase_r == PH_ZERO && word_idx_r == '0))
    else $error("run start did not clear sequencer");

  // Bit position only moves during the walking-ones step
  a_bit_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_pos_r != '0) |-> (phase_r == PH_WALK && running_r))
    else $error("bit position set outside walking ones");
`endif

endmodule

// ===== rtl/mpts_dp.sv =====
// Datapath: address and pattern generation, read-back compare, error count and status.
module mpts_dp #(
  parameter int WORD_BITS = mpts_pkg::WordBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  mpts_pkg::seq_ctl_t ctl,
  input  logic [31:0]        base_address,
  input  logic               test_mode,
  input  logic [31:0]        read_data,
  output logic [1:0]         mem_cmd,
  output logic [31:0]        mem_address,
  output logic [31:0]        mem_write_data,
  output logic [31:0]        error_count,
  output logic [1:0]         test_status
);
  import mpts_pkg::*;

  localparam int PatBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [31:0] PatMask = 32'((64'd1 << PatBits) - 64'd1);

  logic        pend_r, pend_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] err_r, err_nxt;
  logic [1:0]  status_r, status_nxt;

  logic [31:0] addr;
  logic [31:0] pat_raw;
  logic [31:0] pat;
  logic        active;
  logic        miss;
  logic [31:0] err_upd;
  mem_cmd_t    cmd;

  // Address and data pattern
  always_comb begin
    addr = base_address + {ctl.word_idx, 2'b00};
    case (ctl.pat)
      PAT_ZERO: pat_raw = '0;
      PAT_ONES: pat_raw = '1;
      PAT_AA:   pat_raw = 32'hAAAA_AAAA;
      PAT_55:   pat_raw = 32'h5555_5555;
      PAT_WALK: pat_raw = 32'd1 << ctl.bit_pos;
      PAT_ADDR: pat_raw = addr;
      default:  pat_raw = '0;
    endcase
    pat = pat_raw & PatMask;
  end

  // Command outputs
  always_comb begin
    if (!ctl.issue) begin
      cmd = CMD_NONE;
    end else if (ctl.verify) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_WRITE;
    end
    mem_cmd        = cmd;
    mem_address    = ctl.issue ? addr : '0;
    mem_write_data = (ctl.issue && !ctl.verify) ? pat : '0;
  end

  // Read-back compare with saturating error count
  always_comb begin
    active  = ctl.issue || ctl.done;
    miss    = pend_r && active && (read_data != exp_r) && (err_r != '1);
    err_upd = miss ? (err_r + 32'd1) : err_r;
  end

  // Next state
  always_comb begin
    pend_nxt   = pend_r;
    exp_nxt    = exp_r;
    err_nxt    = err_r;
    status_nxt = status_r;
    if (step) begin
      if (ctl.start) begin
        pend_nxt = 1'b0;
        exp_nxt  = '0;
        err_nxt  = '0;
      end else if (active) begin
        err_nxt  = err_upd;
        pend_nxt = ctl.issue && ctl.verify;
        if (ctl.issue && ctl.verify) begin
          exp_nxt = pat;
        end
        if (ctl.done && !test_mode) begin
          status_nxt = (err_upd == '0) ? ST_PASS : ST_FAIL;
        end
      end
    end
  end

  assign error_count = err_nxt;
  assign test_status = status_nxt;

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      exp_r    <= '0;
      err_r    <= '0;
      status_r <= ST_NOT_RUN;
    end else begin
      pend_r   <= pend_nxt;
      exp_r    <= exp_nxt;
      err_r    <= err_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== rtl/memory_pattern_test_sequencer.sv =====
// Top level of the memory pattern test sequencer: config, sequencer, datapath, output stage.
// A result is registered when its input transaction is accepted and is valid in the next cycle.
// Throughput: one transaction per cycle; the input stalls only while a result waits on out_tready.
// A full run takes one start tick, two passes over the region per phase (per bit position
// in walking ones), and one final tick.
// Reset (rst_n low, synchronous) idles the sequencer, clears the error count and status,
// and loads base 0, size 64 KB, full mode; no memory clearing pass is needed.
module memory_pattern_test_sequencer #(
  parameter int WORD_BITS        = mpts_pkg::WordBitsDef,
  parameter int WALK_LIMIT_BYTES = mpts_pkg::WalkLimitDef
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] read_data
  input  logic         in_tuser,   // [0] func
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // mem_cmd, mem_address, mem_write_data, test_phase,
                                   // busy_res, done_res, error_count, test_status, zero fill
  // configuration port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import mpts_pkg::*;

  logic [31:0]  base_r;
  logic [31:0]  size_r;
  logic         mode_r;
  logic         out_valid_r, out_valid_nxt;
  logic [111:0] out_data_r;

  logic         step;
  seq_ctl_t     ctl;
  logic [1:0]   mem_cmd;
  logic [31:0]  mem_address;
  logic [31:0]  mem_write_data;
  logic [31:0]  error_count;
  logic [1:0]   test_status;
  logic [2:0]   test_phase;
  logic         busy_res;
  logic         done_res;

  // Handshake: accept whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= SizeResetVal;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: base_r <= cfg_wdata;
        CFG_SIZE: size_r <= cfg_wdata;
        CFG_MODE: mode_r <= cfg_wdata[0];
        default:  ;
      endcase
    end
  end

  mpts_seq #(
    .WORD_BITS        (WORD_BITS),
    .WALK_LIMIT_BYTES (WALK_LIMIT_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .func       (in_tuser),
    .size_bytes (size_r),
    .test_mode  (mode_r),
    .ctl        (ctl)
  );

  mpts_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .ctl            (ctl),
    .base_address   (base_r),
    .test_mode      (mode_r),
    .read_data      (in_tdata),
    .mem_cmd        (mem_cmd),
    .mem_address    (mem_address),
    .mem_write_data (mem_write_data),
    .error_count    (error_count),
    .test_status    (test_status)
  );

  // Status flags of the tick
  assign test_phase = ctl.issue ? ctl.phase : PH_ZERO;
  assign busy_res   = ctl.start || ctl.issue;
  assign done_res   = ctl.done;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {7'd0, test_status, error_count, done_res, busy_res, test_phase,
                     mem_write_data, mem_address, mem_cmd};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
